### rtl/rc4_pkg.sv
package rc4_pkg;

    localparam int PERM_DEPTH    = 256;
    localparam int BYTE_W        = 8;
    localparam int KEY_BYTES_MAX = 256;
    localparam int KEY_AW        = $clog2(KEY_BYTES_MAX);
    localparam int KEY_CNT_W     = $clog2(KEY_BYTES_MAX + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_NEXT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_WN,
        ST_KS_WJ,
        ST_PR_J,
        ST_PR_WI,
        ST_PR_WJ
    } state_t;

    typedef struct packed {
        logic load;     // store one key byte if there is room
        logic finish;   // latch key length, restart count and key pointer
        logic advance;  // read key byte at pointer, step pointer mod length
    } key_ctl_t;

endpackage

### rtl/rc4_key_store.sv
module rc4_key_store
    import rc4_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_ctl_t          ctl,
    input  logic [BYTE_W-1:0] key_byte,
    output logic [BYTE_W-1:0] key_data
);

    logic [BYTE_W-1:0]    key_mem [KEY_BYTES_MAX];
    logic [KEY_CNT_W-1:0] count_reg, count_next;
    logic [KEY_CNT_W-1:0] len_reg, len_next;
    logic [KEY_AW-1:0]    kp_reg, kp_next;
    logic [BYTE_W-1:0]    key_data_reg;
    logic                 room;

    assign room = count_reg < KEY_CNT_W'(KEY_BYTES_MAX);

    always_comb
    begin
        count_next = count_reg;
        len_next   = len_reg;
        kp_next    = kp_reg;
        if (ctl.load && room)
        begin
            count_next = count_reg + 1'b1;
        end
        if (ctl.finish)
        begin
            len_next   = count_next;
            count_next = '0;
            kp_next    = '0;
        end
        if (ctl.advance)
        begin
            if (({1'b0, kp_reg} + 1'b1) == len_reg)
            begin
                kp_next = '0;
            end
            else
            begin
                kp_next = kp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            len_reg   <= KEY_CNT_W'(1);
            kp_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            len_reg   <= len_next;
            kp_reg    <= kp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && room)
        begin
            key_mem[count_reg[KEY_AW-1:0]] <= key_byte;
        end
        if (ctl.advance)
        begin
            key_data_reg <= key_mem[kp_reg];
        end
    end

    assign key_data = key_data_reg;

endmodule

### rtl/rc4_keystream_generator.sv
// Channel   Ports                                   Beat
// input     start, busy, kind, key_byte, key_last   start & !busy
// result    stream_valid, stream_byte               stream_valid (one cycle)
//
// A next item keeps busy high in ST_PR_J, ST_PR_WI, ST_PR_WJ; stream_valid pulses
// the cycle after ST_PR_WJ. A key byte is taken in ST_IDLE; the final one runs
// ST_INIT to refill the permutation with identity, then per schedule step ST_KS_RD,
// ST_KS_J, ST_KS_WN, ST_KS_WJ (one permutation read/write port). After reset the
// same pass runs with a single zero key; busy is high. Results cannot be stalled.
module rc4_keystream_generator
    import rc4_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [BYTE_W-1:0] key_byte,
    input  logic              key_last,
    output logic              stream_valid,
    output logic [BYTE_W-1:0] stream_byte
);

    state_t state_reg, state_next;

    logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] s_rdata_reg;
    logic              s_we;
    logic [BYTE_W-1:0] s_waddr, s_wdata, s_raddr;

    logic [BYTE_W-1:0] n_reg, n_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] out_reg, out_next;
    logic              strobe_reg, strobe_next;
    logic              zero_key_reg, zero_key_next;

    logic              accept;
    logic [BYTE_W-1:0] key_data;
    logic [BYTE_W-1:0] key_val;
    key_ctl_t          key_ctl;

    assign accept  = start && (state_reg == ST_IDLE);
    assign key_val = zero_key_reg ? '0 : key_data;

    rc4_key_store u_key_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (key_ctl),
        .key_byte (key_byte),
        .key_data (key_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        t_next        = t_reg;
        out_next      = out_reg;
        strobe_next   = 1'b0;
        zero_key_next = zero_key_reg;
        s_we          = 1'b0;
        s_waddr       = n_reg;
        s_wdata       = n_reg;
        s_raddr       = n_reg;
        key_ctl       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_NEXT)
                    begin
                        i_next     = i_reg + 1'b1;
                        s_raddr    = i_reg + 1'b1;
                        state_next = ST_PR_J;
                    end
                    else
                    begin
                        key_ctl.load = 1'b1;
                        if (key_last)
                        begin
                            key_ctl.finish = 1'b1;
                            n_next         = '0;
                            state_next     = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                s_we   = 1'b1;
                n_next = n_reg + 1'b1;
                if (n_reg == BYTE_W'(PERM_DEPTH - 1))
                begin
                    j_next     = '0;
                    state_next = ST_KS_RD;
                end
            end
            ST_KS_RD:
            begin
                key_ctl.advance = 1'b1;
                state_next      = ST_KS_J;
            end
            ST_KS_J:
            begin
                si_next    = s_rdata_reg;
                j_next     = j_reg + s_rdata_reg + key_val;
                s_raddr    = j_reg + s_rdata_reg + key_val;
                state_next = ST_KS_WN;
            end
            ST_KS_WN:
            begin
                s_we       = 1'b1;
                s_waddr    = n_reg;
                s_wdata    = s_rdata_reg;
                state_next = ST_KS_WJ;
            end
            ST_KS_WJ:
            begin
                s_we    = 1'b1;
                s_waddr = j_reg;
                s_wdata = si_reg;
                n_next  = n_reg + 1'b1;
                if (n_reg == BYTE_W'(PERM_DEPTH - 1))
                begin
                    i_next        = '0;
                    j_next        = '0;
                    zero_key_next = 1'b0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_KS_RD;
                end
            end
            ST_PR_J:
            begin
                si_next    = s_rdata_reg;
                j_next     = j_reg + s_rdata_reg;
                s_raddr    = j_reg + s_rdata_reg;
                state_next = ST_PR_WI;
            end
            ST_PR_WI:
            begin
                s_we       = 1'b1;
                s_waddr    = i_reg;
                s_wdata    = s_rdata_reg;
                sj_next    = s_rdata_reg;
                t_next     = si_reg + s_rdata_reg;
                s_raddr    = si_reg + s_rdata_reg;
                state_next = ST_PR_WJ;
            end
            ST_PR_WJ:
            begin
                s_we    = 1'b1;
                s_waddr = j_reg;
                s_wdata = si_reg;
                // output read saw the pre-swap array; patch in the swapped pair
                if (t_reg == j_reg)
                begin
                    out_next = si_reg;
                end
                else if (t_reg == i_reg)
                begin
                    out_next = sj_reg;
                end
                else
                begin
                    out_next = s_rdata_reg;
                end
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            n_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            strobe_reg   <= 1'b0;
            zero_key_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            strobe_reg   <= strobe_next;
            zero_key_reg <= zero_key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg  <= si_next;
        sj_reg  <= sj_next;
        t_reg   <= t_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            perm_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= perm_mem[s_raddr];
    end

    assign busy         = (state_reg != ST_IDLE);
    assign stream_valid = strobe_reg;
    assign stream_byte  = out_reg;

    a_next_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_NEXT) |-> ##4 stream_valid)
        else $error("keystream beat missing four cycles after next item");

    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stream_valid |-> (!busy && $past(state_reg) == ST_PR_WJ))
        else $error("keystream beat outside end of output step");

    a_reset_key_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !zero_key_reg)
        else $error("idle before reset key schedule finished");

endmodule

### tb/sv/rc4_keystream_generator_test.sv
`timescale 1ns / 100ps

import rc4_pkg::*;

class rc4_keystream_ledger;
    bit [BYTE_W-1:0] sbox [PERM_DEPTH];
    bit [BYTE_W-1:0] key_buf [KEY_BYTES_MAX];
    bit [BYTE_W-1:0] idx_i;
    bit [BYTE_W-1:0] idx_j;
    int unsigned     key_len;
    bit [BYTE_W-1:0] pending_stream [$];
    int              fail_count;
    int              shown;

    function new();
        key_len    = 0;
        fail_count = 0;
        shown      = 0;
        foreach (key_buf[n])
            key_buf[n] = '0;
        // power-up state: schedule of one zero key byte
        schedule_key(1);
    endfunction

    function void schedule_key(int unsigned len);
        bit [BYTE_W-1:0] jj;
        bit [BYTE_W-1:0] t;
        jj = '0;
        for (int n = 0; n < PERM_DEPTH; n++)
            sbox[n] = BYTE_W'(n);
        for (int n = 0; n < PERM_DEPTH; n++)
        begin
            jj      = jj + sbox[n] + key_buf[n % len];
            t       = sbox[n];
            sbox[n] = sbox[jj];
            sbox[jj] = t;
        end
        idx_i = '0;
        idx_j = '0;
    endfunction

    // Returns 0 for a key byte that is simply dropped (key buffer full, no final mark).
    function bit absorb_beat(logic k, logic [BYTE_W-1:0] kb, logic kl);
        bit [BYTE_W-1:0] t;
        bit [BYTE_W-1:0] sum;
        bit              took;
        took = 1'b1;
        if (k == KIND_LOAD)
        begin
            if (key_len < KEY_BYTES_MAX)
            begin
                key_buf[key_len] = kb;
                key_len++;
            end
            else
                took = kl;
            if (kl)
            begin
                schedule_key(key_len);
                key_len = 0;
            end
        end
        else
        begin
            idx_i        = idx_i + 1'b1;
            idx_j        = idx_j + sbox[idx_i];
            t            = sbox[idx_i];
            sbox[idx_i]  = sbox[idx_j];
            sbox[idx_j]  = t;
            sum          = sbox[idx_i] + sbox[idx_j];
            pending_stream.push_back(sbox[sum]);
        end
        return took;
    endfunction

    function void check_stream_byte(logic [BYTE_W-1:0] got);
        bit [BYTE_W-1:0] want;
        if (pending_stream.size() == 0)
        begin
            fail_count++;
            if (shown < 10)
            begin
                shown++;
                $display("stream byte %02h with no keystream step pending", got);
            end
            return;
        end
        want = pending_stream.pop_front();
        if (got !== want)
        begin
            fail_count++;
            if (shown < 10)
            begin
                shown++;
                $display("stream byte mismatch: expected %02h, got %02h", want, got);
            end
        end
    endfunction
endclass

module rc4_keystream_generator_test;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              kind;
    logic [BYTE_W-1:0] key_byte;
    logic              key_last;
    logic              stream_valid;
    logic [BYTE_W-1:0] stream_byte;

    rc4_keystream_ledger ledger;
    int                  beats_sent;
    int                  burst_left;
    int                  gap_len;

    rc4_keystream_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .key_byte     (key_byte),
        .key_last     (key_last),
        .stream_valid (stream_valid),
        .stream_byte  (stream_byte)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && stream_valid === 1'b1 && ledger != null)
            ledger.check_stream_byte(stream_byte);
    end

    initial
    begin
        #(60_000_000);
        $display("rc4_keystream_generator_test: FAIL");
        $finish;
    end

    // Holds start high until the beat is taken; leaves start high on return.
    task automatic send_beat(logic k, logic [BYTE_W-1:0] kb, logic kl);
        start    <= 1'b1;
        kind     <= k;
        key_byte <= kb;
        key_last <= kl;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (ledger.absorb_beat(k, kb, kl))
            beats_sent++;
    endtask

    task automatic send_item(logic k, logic [BYTE_W-1:0] kb, logic kl);
        if (burst_left == 0)
        begin
            if (gap_len > 0)
            begin
                start <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(20, 80);
            else
                burst_left = $urandom_range(1, 12);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
        burst_left--;
        send_beat(k, kb, kl);
    endtask

    task automatic wait_drained();
        if (ledger.pending_stream.size() != 0)
        begin
            start <= 1'b0;
            while (ledger.pending_stream.size() != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        int klen;
        int cnt;
        int roll;
        int guard;
        bit first_long;

        ledger     = new();
        beats_sent = 0;
        burst_left = 0;
        gap_len    = 0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        kind       <= KIND_LOAD;
        key_byte   <= '0;
        key_last   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // keystream straight out of reset
        send_item(KIND_NEXT, 8'h00, 1'b0);
        send_item(KIND_NEXT, 8'hFF, 1'b1);
        send_item(KIND_NEXT, 8'h5A, 1'b0);
        // three-byte key
        send_item(KIND_LOAD, 8'h4B, 1'b0);
        send_item(KIND_LOAD, 8'h65, 1'b0);
        send_item(KIND_LOAD, 8'h79, 1'b1);
        send_item(KIND_NEXT, 8'h00, 1'b0);
        send_item(KIND_NEXT, 8'h00, 1'b1);
        send_item(KIND_NEXT, 8'hA5, 1'b0);
        // single-byte keys at both extremes
        send_item(KIND_LOAD, 8'hFF, 1'b1);
        send_item(KIND_NEXT, 8'h00, 1'b0);
        send_item(KIND_NEXT, 8'hFF, 1'b0);
        send_item(KIND_LOAD, 8'h00, 1'b1);
        send_item(KIND_NEXT, 8'h3C, 1'b0);
        // keystream while a key is half loaded, then finish that key
        send_item(KIND_LOAD, 8'hAA, 1'b0);
        send_item(KIND_NEXT, 8'h00, 1'b0);
        send_item(KIND_NEXT, 8'hFF, 1'b1);
        send_item(KIND_LOAD, 8'h55, 1'b1);
        send_item(KIND_NEXT, 8'h00, 1'b0);
        send_item(KIND_NEXT, 8'h00, 1'b0);
        wait_drained();

        first_long = 1'b1;
        while (beats_sent < 750)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                // first well-formed key is 250-300 bytes, may overrun the key buffer
                if (first_long || $urandom_range(0, 19) == 0)
                    klen = $urandom_range(250, 300);
                else
                    klen = $urandom_range(1, 16);
                first_long = 1'b0;
                for (int n = 0; n < klen; n++)
                begin
                    send_item(KIND_LOAD, BYTE_W'($urandom_range(0, 255)), n == klen - 1);
                    if (n < klen - 1 && $urandom_range(0, 15) == 0)
                        send_item(KIND_NEXT, BYTE_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                end
                cnt = $urandom_range(1, 24);
                repeat (cnt)
                    send_item(KIND_NEXT, BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
            else if (roll < 95)
            begin
                cnt = $urandom_range(1, 8);
                repeat (cnt)
                    send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                              $urandom_range(0, 7) == 0);
            end
            else
                wait_drained();
        end

        start <= 1'b0;
        guard = 0;
        while (ledger.pending_stream.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);

        if (ledger.fail_count == 0 && ledger.pending_stream.size() == 0)
            $display("rc4_keystream_generator_test: PASS");
        else
            $display("rc4_keystream_generator_test: FAIL");
        $finish;
    end

endmodule
